// ===== hw/rtl/assert_macros.svh =====
// assertion helpers, sampled on clk_i and quiet while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a condition that holds at every clock edge
`define SKT_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// an implication checked in the same cycle
`define SKT_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/skt_pkg.sv =====
`default_nettype none

package skt_pkg;

  localparam int unsigned DEPTH_DEF        = 256;
  localparam int unsigned KEY_BITS_DEF     = 32;
  localparam int unsigned PAYLOAD_BITS_DEF = 32;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_DUP     = 2'd1,
    ST_MISSING = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] key;
    logic [31:0] payload;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] payload_out;
    logic [8:0]  count;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic    start;
    logic    srch_rd;
    logic    srch_cmp;
    logic    chk_rd;
    logic    chk_cmp;
    logic    miss;
    logic    shift_init;
    logic    shift_step;
    logic    fill;
    logic    cnt_dec;
    logic    ld_out;
    status_e status;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_done;
    logic pos_valid;
    logic hit;
    logic full;
    logic is_ins;
    logic is_rem;
    logic shift_more;
  } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/skt_datapath.sv =====
`default_nettype none

`include "assert_macros.svh"

module skt_datapath import skt_pkg::*; #(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output sts_t sts_o,
  output out_t out_data_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [KEY_BITS-1:0]     key_mem [DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [DEPTH];

  logic [1:0]              op_q, op_d;
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pin_q, pin_d;
  logic [CW-1:0]           lo_q, lo_d, hi_q, hi_d, count_q, count_d, ptr_q, ptr_d;
  logic                    dir_up_q, dir_up_d;
  logic                    pend_q, pend_d;
  logic [AW-1:0]           pend_addr_q, pend_addr_d;
  logic                    hit_q, hit_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;
  logic [KEY_BITS-1:0]     rd_key_q;
  logic [PAYLOAD_BITS-1:0] rd_pay_q;
  out_t                    out_q, out_d;

  logic [CW-1:0]           mid, ptr_m1, ptr_p1;
  logic                    key_eq;
  logic                    rd_en, wr_en;
  logic [AW-1:0]           rd_addr, wr_addr;
  logic [KEY_BITS-1:0]     wr_key;
  logic [PAYLOAD_BITS-1:0] wr_pay;

  assign mid    = lo_q + ((hi_q - lo_q) >> 1);
  assign ptr_m1 = ptr_q - CW'(1);
  assign ptr_p1 = ptr_q + CW'(1);
  assign key_eq = (rd_key_q == key_q);

  always_comb begin
    op_d        = op_q;
    key_d       = key_q;
    pin_d       = pin_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    count_d     = count_q;
    ptr_d       = ptr_q;
    dir_up_d    = dir_up_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    hit_d       = hit_q;
    pay_d       = pay_q;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = mid[AW-1:0];
    wr_en       = 1'b0;
    wr_addr     = pend_addr_q;
    wr_key      = rd_key_q;
    wr_pay      = rd_pay_q;

    if (cmd_i.start) begin
      op_d  = in_data_i.op;
      key_d = KEY_BITS'(in_data_i.key);
      pin_d = PAYLOAD_BITS'(in_data_i.payload);
      lo_d  = '0;
      hi_d  = count_q;
    end
    if (cmd_i.srch_rd) begin
      rd_en   = 1'b1;
      rd_addr = mid[AW-1:0];
    end
    if (cmd_i.srch_cmp) begin
      if (rd_key_q < key_q) begin
        lo_d = mid + CW'(1);
      end else begin
        hi_d = mid;
      end
    end
    if (cmd_i.chk_rd) begin
      rd_en   = 1'b1;
      rd_addr = lo_q[AW-1:0];
    end
    if (cmd_i.chk_cmp) begin
      hit_d = key_eq;
      pay_d = key_eq ? rd_pay_q : '0;
    end
    if (cmd_i.miss) begin
      hit_d = 1'b0;
      pay_d = '0;
    end
    if (cmd_i.shift_init) begin
      dir_up_d = (op_q == OP_INSERT);
      ptr_d    = (op_q == OP_INSERT) ? count_q : lo_q;
      pend_d   = 1'b0;
    end
    if (cmd_i.shift_step) begin
      // write lands in the cycle after its read
      wr_en = pend_q;
      if (dir_up_q) begin
        if (ptr_q > lo_q) begin
          rd_en       = 1'b1;
          rd_addr     = ptr_m1[AW-1:0];
          ptr_d       = ptr_m1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[AW-1:0];
        end else begin
          pend_d = 1'b0;
        end
      end else begin
        if (ptr_p1 < count_q) begin
          rd_en       = 1'b1;
          rd_addr     = ptr_p1[AW-1:0];
          ptr_d       = ptr_p1;
          pend_d      = 1'b1;
          pend_addr_d = ptr_q[AW-1:0];
        end else begin
          pend_d = 1'b0;
        end
      end
    end
    if (cmd_i.fill) begin
      wr_en   = 1'b1;
      wr_addr = lo_q[AW-1:0];
      wr_key  = key_q;
      wr_pay  = pin_q;
      count_d = count_q + CW'(1);
    end
    if (cmd_i.cnt_dec) begin
      count_d = count_q - CW'(1);
    end
    if (cmd_i.ld_out) begin
      out_d.status      = cmd_i.status;
      out_d.found       = hit_q;
      out_d.payload_out = 32'(pay_q);
      out_d.count       = 9'(count_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      lo_q     <= '0;
      hi_q     <= '0;
      ptr_q    <= '0;
      pend_q   <= 1'b0;
      dir_up_q <= 1'b0;
    end else begin
      count_q  <= count_d;
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      ptr_q    <= ptr_d;
      pend_q   <= pend_d;
      dir_up_q <= dir_up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    key_q       <= key_d;
    pin_q       <= pin_d;
    pend_addr_q <= pend_addr_d;
    hit_q       <= hit_d;
    pay_q       <= pay_d;
    out_q       <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      pay_mem[wr_addr] <= wr_pay;
    end
    if (rd_en) begin
      rd_key_q <= key_mem[rd_addr];
      rd_pay_q <= pay_mem[rd_addr];
    end
  end

  assign sts_o.srch_done  = (lo_q == hi_q);
  assign sts_o.pos_valid  = (lo_q < count_q);
  assign sts_o.hit        = hit_q;
  assign sts_o.full       = (count_q == CW'(DEPTH));
  assign sts_o.is_ins     = (op_q == OP_INSERT);
  assign sts_o.is_rem     = (op_q == OP_REMOVE);
  assign sts_o.shift_more = pend_q || (dir_up_q ? (ptr_q > lo_q) : (ptr_p1 < count_q));

  assign out_data_o = out_q;

  `SKT_ASSERT(a_bounds_ordered, lo_q <= hi_q, "search bounds crossed")
  `SKT_ASSERT(a_count_limit, count_q <= CW'(DEPTH), "entry count above depth")
  `SKT_ASSERT_IMPL(a_no_rw_clash, wr_en && rd_en, wr_addr != rd_addr, "shift read hits write")
  `SKT_ASSERT_IMPL(a_count_step, !$stable(count_q), (count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1)), "count jumped")

endmodule

`default_nettype wire

// ===== hw/rtl/skt_ctrl.sv =====
`default_nettype none

`include "assert_macros.svh"

module skt_ctrl import skt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_stall_o,
  output logic out_valid_o
);

  typedef enum logic [7:0] {
    S_IDLE     = 8'b0000_0001,
    S_SRCH     = 8'b0000_0010,
    S_SRCH_CMP = 8'b0000_0100,
    S_CHECK    = 8'b0000_1000,
    S_DECIDE   = 8'b0001_0000,
    S_SHIFT    = 8'b0010_0000,
    S_FILL     = 8'b0100_0000,
    S_FINISH   = 8'b1000_0000
  } state_e;

  state_e  state_q, state_d;
  status_e status_q, status_d;
  logic    out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    status_d   = status_q;
    cmd_o      = '0;
    cmd_o.status = status_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_SRCH;
        end
      end
      S_SRCH: begin
        if (!sts_i.srch_done) begin
          cmd_o.srch_rd = 1'b1;
          state_d       = S_SRCH_CMP;
        end else if (sts_i.pos_valid) begin
          cmd_o.chk_rd = 1'b1;
          state_d      = S_CHECK;
        end else begin
          cmd_o.miss = 1'b1;
          state_d    = S_DECIDE;
        end
      end
      S_SRCH_CMP: begin
        cmd_o.srch_cmp = 1'b1;
        state_d        = S_SRCH;
      end
      S_CHECK: begin
        cmd_o.chk_cmp = 1'b1;
        state_d       = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts_i.is_ins) begin
          if (sts_i.hit) begin
            status_d = ST_DUP;
            state_d  = S_FINISH;
          end else if (sts_i.full) begin
            status_d = ST_FULL;
            state_d  = S_FINISH;
          end else begin
            status_d         = ST_DONE;
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT;
          end
        end else if (sts_i.is_rem) begin
          if (!sts_i.hit) begin
            status_d = ST_MISSING;
            state_d  = S_FINISH;
          end else begin
            status_d         = ST_DONE;
            cmd_o.shift_init = 1'b1;
            state_d          = S_SHIFT;
          end
        end else begin
          status_d = sts_i.hit ? ST_DONE : ST_MISSING;
          state_d  = S_FINISH;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_step = 1'b1;
        end else if (sts_i.is_ins) begin
          state_d = S_FILL;
        end else begin
          cmd_o.cnt_dec = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        state_d    = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.ld_out = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.ld_out || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      status_q    <= ST_DONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      status_q    <= status_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  `SKT_ASSERT_IMPL(a_valid_from_finish, $rose(out_valid_q), $past(state_q == S_FINISH), "result without finish")
  `SKT_ASSERT_IMPL(a_fill_only_insert, state_q == S_FILL, sts_i.is_ins && !sts_i.full, "fill outside insert")

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_key_table.sv =====
// sorted key table: (key, payload) entries held in ascending key order
//
// input channel in_valid_i / in_stall_o carries one transaction per
// operation: op (insert, remove, lookup; code 3 acts as lookup), key, payload
// output channel out_valid_o / out_stall_i returns exactly one transaction per
// operation: status, found, payload_out and the entry count afterwards
// one operation is in flight at a time; in_stall_o is low only when idle
// after the accepting edge: binary search steps, each a read then a compare
// (S_SRCH, S_SRCH_CMP), then the hit check read and compare (skipped when the
// position is past the last entry), the decide state, then for insert/remove
// a shift that moves one entry at a time, a write of a new entry for insert,
// and the load of the result register; the sequencer returns to idle before
// the next accept; the shift is bounded by the single read port and single
// write port of the entry memory
// a finished result sits in the output register; the next operation is
// taken while it waits, and only its own completion waits for out_stall_i
// reset empties the table (count to zero) and clears out_valid_o;
// the entry memory itself is not cleared, only entries below count are read
`default_nettype none

module sorted_key_table import skt_pkg::*; #(
  parameter int unsigned DEPTH        = DEPTH_DEF,
  parameter int unsigned KEY_BITS     = KEY_BITS_DEF,
  parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // operation transactions
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  // result transactions
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  // sequencer: search, shift and result hand-off
  skt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_stall_i(out_stall_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o)
  );

  // entry memory, search bounds, shift pointer and result register
  skt_datapath #(
    .DEPTH       (DEPTH),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .in_data_i (in_data_i),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire
